>>> hdl/histeq_pkg.sv
//------------------------------------------------------------------------------
// histeq_pkg
// Shared types and constants for the histogram equalization core.
//------------------------------------------------------------------------------
`default_nettype none
package histeq_pkg;
  localparam int unsigned Bins      = 256;
  localparam int unsigned BinW      = 8;
  localparam int unsigned CntW      = 25;
  localparam int unsigned FreqW     = 17;
  localparam int unsigned FracBits  = 16;
  localparam logic [CntW-1:0] MaxPixels = 25'd16777216;
  localparam logic [BinW-1:0] MaxLevel  = 8'd255;

  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_READ   = 1'b1;

  typedef enum logic [3:0] {
    ST_CLEAR,   // sweep after reset
    ST_IDLE,
    ST_NEWFRM,  // clear histogram before a new frame
    ST_WALK,    // bin walk
    ST_WDIV,    // level divider busy
    ST_WUPD,    // equalized RMW
    ST_ACK,
    ST_RDWAIT,  // read memory latency
    ST_RDDIV,   // frequency divider
    ST_OUT
  } state_t;

  // divider request/response
  typedef struct packed {
    logic        start;
    logic [40:0] num;
    logic [25:0] den;
  } div_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [40:0] quo;
  } div_rsp_t;
endpackage
`default_nettype wire

>>> hdl/histogram_equalization_core.sv
//------------------------------------------------------------------------------
// histogram_equalization_core
// 256-bin histogram of 8-bit frames, CDF level map and equalized histogram.
//------------------------------------------------------------------------------
// Channel | Dir | Word
// in_     | in  | tdata {bin[15:8], pixel[7:0]}, tuser {req_type}, tlast frame_last
// out_    | out | tdata {freq[76:60], count[59:35], level[34:27], empty[26],
//         |     |        ovf[25], size[24:0]}
//
// A pixel's histogram bin is read and then written back; no word is accepted
// while that write is pending. The last pixel starts the bin walk; the shared
// bit-serial divider forms each level. Reads of a closed, non-empty frame use
// the divider for the frequency. A new frame first sweeps all three memories
// and then counts its held pixel. After reset a clearing pass runs over all
// three memories; no word is accepted then. Output is a register: the core
// waits for it to drain before delivering the next result.
//------------------------------------------------------------------------------
`default_nettype none
module histogram_equalization_core
  import histeq_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,  // pixel[7:0], bin[15:8]
  input  wire logic        in_tuser,  // req_type
  input  wire logic        in_tlast,  // frame_last
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [79:0]      out_tdata  // frame_size[24:0] overflow[25] empty[26]
                                      // level[34:27] count[59:35] freq[76:60]
);
  // memories
  logic [CntW-1:0] hist_mem [Bins];
  logic [BinW-1:0] lvl_mem  [Bins];
  logic [CntW-1:0] eq_mem   [Bins];
  logic [CntW-1:0] hist_q, eq_q;
  logic [BinW-1:0] lvl_q;
  logic [BinW-1:0] h_ra, e_ra, l_ra, h_wa, e_wa, l_wa;
  logic            h_we, e_we, l_we;
  logic [CntW-1:0] h_wd, e_wd;
  logic [BinW-1:0] l_wd;

  always_ff @(posedge clk) begin
    if (h_we) hist_mem[h_wa] <= h_wd;
    if (e_we) eq_mem[e_wa] <= e_wd;
    if (l_we) lvl_mem[l_wa] <= l_wd;
    hist_q <= hist_mem[h_ra];
    eq_q   <= eq_mem[e_ra];
    lvl_q  <= lvl_mem[l_ra];
  end

  state_t          st_r, st_nxt;
  logic [8:0]      idx_r, idx_nxt;         // sweep / walk index
  logic [CntW-1:0] tot_r, tot_nxt;
  logic            ovf_r, ovf_nxt, closed_r, closed_nxt;
  logic [33:0]     cum_r, cum_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;         // bin count held during walk
  logic [BinW-1:0] pix_r, pix_nxt;
  logic            last_r, last_nxt, pend_r, pend_nxt;
  logic            ovalid_r, ovalid_nxt;
  logic [79:0]     odata_r, odata_nxt;
  logic [BinW-1:0] lvl_r, lvl_nxt;
  logic [CntW-1:0] ecnt_r, ecnt_nxt;
  div_req_t        dreq;
  div_rsp_t        drsp;

  histeq_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  wire acc_in = in_tvalid && in_tready;
  wire out_free = !ovalid_r || out_tready;

  function automatic logic [79:0] pack_out(logic [CntW-1:0] t, logic o, logic e,
                                           logic [7:0] l, logic [CntW-1:0] c,
                                           logic [FreqW-1:0] f);
    pack_out = {3'b0, f, c, l, e, o, t};
  endfunction

  always_comb begin
    st_nxt = st_r; idx_nxt = idx_r; tot_nxt = tot_r; ovf_nxt = ovf_r;
    closed_nxt = closed_r; cum_nxt = cum_r; cnt_nxt = cnt_r;
    pix_nxt = pix_r; last_nxt = last_r; pend_nxt = 1'b0;
    lvl_nxt = lvl_r; ecnt_nxt = ecnt_r;
    ovalid_nxt = ovalid_r && !out_tready; odata_nxt = odata_r;
    in_tready = 1'b0;
    h_we = 1'b0; e_we = 1'b0; l_we = 1'b0;
    h_wa = pix_r; e_wa = idx_r[7:0]; l_wa = idx_r[7:0];
    h_wd = '0; e_wd = '0; l_wd = '0;
    h_ra = in_tdata[7:0]; e_ra = in_tdata[15:8]; l_ra = in_tdata[15:8];
    dreq = '0;
    case (st_r)
      ST_CLEAR: begin
        h_we = 1'b1; e_we = 1'b1; l_we = 1'b1; h_wa = idx_r[7:0];
        idx_nxt = 9'(idx_r + 9'd1);
        if (idx_r == 9'd255) st_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        // finish pending histogram write from previous pixel
        if (pend_r) begin
          h_we = 1'b1; h_wd = 25'(hist_q + 25'd1);
        end
        in_tready = !pend_r && out_free;
        if (acc_in) begin
          pix_nxt = in_tdata[7:0];
          last_nxt = in_tlast;
          if (in_tuser == REQ_READ) begin
            st_nxt = ST_RDWAIT;
          end else if (closed_r) begin
            tot_nxt = '0; ovf_nxt = 1'b0; closed_nxt = 1'b0;
            idx_nxt = '0; st_nxt = ST_NEWFRM;
          end else if (tot_r == MaxPixels) begin
            ovf_nxt = 1'b1;
            if (in_tlast) begin idx_nxt = '0; cum_nxt = '0; st_nxt = ST_WALK; end
          end else begin
            tot_nxt = 25'(tot_r + 25'd1);
            pend_nxt = 1'b1;
            if (in_tlast) st_nxt = ST_WALK;
            idx_nxt = '0; cum_nxt = '0;
          end
        end
      end
      ST_NEWFRM: begin
        // clear histogram, level map and equalized counts of the old frame
        h_we = 1'b1; e_we = 1'b1; l_we = 1'b1; h_wa = idx_r[7:0];
        idx_nxt = 9'(idx_r + 9'd1);
        if (idx_r == 9'd256) begin
          // now count the held pixel (total is zero, never full)
          e_we = 1'b0; l_we = 1'b0;
          tot_nxt = 25'd1; h_wa = pix_r; h_wd = 25'd1;
          idx_nxt = '0; cum_nxt = '0;
          st_nxt = last_r ? ST_WALK : ST_IDLE;
        end
      end
      ST_WALK: begin
        // pending write from last pixel lands here; issue read of bin idx
        if (pend_r) begin h_we = 1'b1; h_wd = 25'(hist_q + 25'd1); end
        h_ra = idx_r[7:0];
        if (idx_r == 9'd256) begin
          st_nxt = ST_ACK;
        end else if (pend_r) begin
          pend_nxt = 1'b0;  // replay so read sees write
        end else if (tot_r == '0) begin
          idx_nxt = 9'(idx_r + 9'd1);
        end else begin
          st_nxt = ST_WDIV;
        end
      end
      ST_WDIV: begin
        if (!drsp.busy && !drsp.done) begin
          cnt_nxt = hist_q;
          cum_nxt = 34'(cum_r + 34'(hist_q));
          dreq.start = 1'b1;
          dreq.num = 41'(({7'd0, cum_r + 34'(hist_q)} * 41'd510) + 41'(tot_r));
          dreq.den = {tot_r, 1'b0};
        end
        e_ra = 8'(drsp.quo > 41'd255 ? MaxLevel : drsp.quo[7:0]);
        if (drsp.done) begin
          lvl_nxt = e_ra;
          l_we = 1'b1; l_wd = e_ra;
          st_nxt = ST_WUPD;
        end
      end
      ST_WUPD: begin
        e_we = 1'b1; e_wa = lvl_r; e_wd = 25'(eq_q + cnt_r);
        idx_nxt = 9'(idx_r + 9'd1);
        st_nxt = ST_WALK;
      end
      ST_ACK: begin
        if (out_free) begin
          closed_nxt = 1'b1;
          ovalid_nxt = 1'b1;
          odata_nxt = pack_out(tot_r, ovf_r, tot_r == '0, '0, '0, '0);
          st_nxt = ST_IDLE;
        end
      end
      ST_RDWAIT: begin
        lvl_nxt = lvl_q; ecnt_nxt = eq_q;
        if (closed_r && tot_r != '0) st_nxt = ST_RDDIV;
        else begin lvl_nxt = '0; ecnt_nxt = '0; st_nxt = ST_OUT; end
      end
      ST_RDDIV: begin
        if (!drsp.busy && !drsp.done) begin
          dreq.start = 1'b1;
          dreq.num = {ecnt_r, 16'd0};
          dreq.den = {1'b0, tot_r};
        end
        if (drsp.done) st_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) begin
          ovalid_nxt = 1'b1;
          odata_nxt = pack_out(tot_r, ovf_r, closed_r && tot_r == '0, lvl_r,
                               ecnt_r, (closed_r && tot_r != '0) ?
                               drsp.quo[FreqW-1:0] : '0);
          st_nxt = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_CLEAR; idx_r <= '0; tot_r <= '0; ovf_r <= 1'b0;
      closed_r <= 1'b0; pend_r <= 1'b0; ovalid_r <= 1'b0;
    end else begin
      st_r <= st_nxt; idx_r <= idx_nxt; tot_r <= tot_nxt; ovf_r <= ovf_nxt;
      closed_r <= closed_nxt; pend_r <= pend_nxt; ovalid_r <= ovalid_nxt;
    end
    cum_r <= cum_nxt; cnt_r <= cnt_nxt; pix_r <= pix_nxt;
    last_r <= last_nxt; lvl_r <= lvl_nxt; ecnt_r <= ecnt_nxt; odata_r <= odata_nxt;
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = odata_r;
endmodule
`default_nettype wire

>>> hdl/histeq_div.sv
//------------------------------------------------------------------------------
// histeq_div
// Radix-2 restoring divider, one quotient bit per cycle.
//------------------------------------------------------------------------------
`default_nettype none
module histeq_div
  import histeq_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);
  logic [40:0] q_r, q_nxt;
  logic [25:0] rem_r, rem_nxt, den_r;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt, done_r, done_nxt;
  logic [26:0] trial;

  always_comb begin
    q_nxt = q_r; rem_nxt = rem_r; cnt_nxt = cnt_r;
    busy_nxt = busy_r; done_nxt = 1'b0;
    trial = {rem_r, q_r[40]};
    if (req.start) begin
      q_nxt = req.num; rem_nxt = '0; cnt_nxt = 6'd41; busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = 26'(trial - {1'b0, den_r});
        q_nxt = {q_r[39:0], 1'b1};
      end else begin
        rem_nxt = trial[25:0];
        q_nxt = {q_r[39:0], 1'b0};
      end
      cnt_nxt = 6'(cnt_r - 6'd1);
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0; done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0; cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt; done_r <= done_nxt; cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt; rem_r <= rem_nxt;
    if (req.start) den_r <= req.den;
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.quo  = q_r;
endmodule
`default_nettype wire

>>> hdl/histeq_chk.sv
//------------------------------------------------------------------------------
// histeq_chk
// Port-level checks for the histogram equalization core.
//------------------------------------------------------------------------------
`default_nettype none
module histeq_chk (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [79:0] out_tdata
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word dropped while stalled");
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_tvalid && !in_tready)
    else $error("active after reset");
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[26] |-> out_tdata[24:0] == 25'd0)
    else $error("empty flag with pixels");
  a_freq: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[76:60] <= 17'd65536)
    else $error("frequency above one");
endmodule

bind histogram_equalization_core histeq_chk u_chk (.*);
`default_nettype wire
